FILE: src/integer_to_roman_numeral_top_defines.svh
`ifndef INTEGER_TO_ROMAN_NUMERAL_TOP_DEFINES_SVH
`define INTEGER_TO_ROMAN_NUMERAL_TOP_DEFINES_SVH

// Concurrent check sampled on clk_i, off while rst_ni is low.
`define I2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Overlapping implication check.
`define I2R_ASSERT_IMP(lbl, ante, cons, msg) \
  `I2R_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication check.
`define I2R_ASSERT_NXT(lbl, ante, cons, msg) \
  `I2R_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: src/i2r_pkg.sv
package i2r_pkg;

  localparam int ValueW    = 12;
  localparam int CharW     = 8;
  localparam int NumSteps  = 13;
  localparam int StepW     = $clog2(NumSteps);
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam logic [ValueW-1:0] MaxValue = 12'd3999;

  localparam logic [CharW-1:0] ChNone = 8'h00;
  localparam logic [CharW-1:0] ChI    = 8'h49;
  localparam logic [CharW-1:0] ChV    = 8'h56;
  localparam logic [CharW-1:0] ChX    = 8'h58;
  localparam logic [CharW-1:0] ChL    = 8'h4C;
  localparam logic [CharW-1:0] ChC    = 8'h43;
  localparam logic [CharW-1:0] ChD    = 8'h44;
  localparam logic [CharW-1:0] ChM    = 8'h4D;

  localparam logic [ValueW-1:0] StepAmount [NumSteps] = '{
    12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
    12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
  };
  localparam logic [CharW-1:0] StepFirst [NumSteps] = '{
    ChM, ChC, ChD, ChC, ChC, ChX, ChL, ChX, ChX, ChI, ChV, ChI, ChI
  };
  localparam logic [CharW-1:0] StepSecond [NumSteps] = '{
    ChNone, ChM, ChNone, ChD, ChNone, ChC, ChNone, ChL, ChNone, ChX, ChNone, ChV, ChNone
  };

  // Classified item as it waits in the queue
  typedef struct packed {
    logic              bad;
    logic [ValueW-1:0] value;
  } item_t;

  // Queue head as the back end sees it
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  // One result character
  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
    logic             invalid;
  } res_t;

  // Largest step amount that fits in the remainder
  function automatic logic [StepW-1:0] find_step(logic [ValueW-1:0] rest);
    logic [StepW-1:0] idx;
    logic             hit;
    idx = StepW'(NumSteps - 1);
    hit = 1'b0;
    for (int s = 0; s < NumSteps; s++) begin
      if (!hit && rest >= StepAmount[s]) begin
        idx = StepW'(s);
        hit = 1'b1;
      end
    end
    return idx;
  endfunction

endpackage

FILE: src/i2r_in_if.sv
interface i2r_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: src/i2r_out_if.sv
interface i2r_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  logic       invalid;

  modport source (output valid, output char_code, output last_char, output invalid,
                  input ready);
  modport sink   (input valid, input char_code, input last_char, input invalid,
                  output ready);
endinterface

FILE: src/i2r_queue.sv
module i2r_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2r_pkg::item_t  item_i,
  output logic            full_o,
  input  logic            pop_i,
  output i2r_pkg::head_t  head_o
);

  i2r_pkg::item_t                  entry_q [i2r_pkg::QDepth];
  logic [i2r_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [i2r_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [i2r_pkg::QCntW-1:0]       count_q, count_d;
  logic                            do_push, do_pop;

  assign full_o       = (count_q == i2r_pkg::QCntW'(i2r_pkg::QDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == i2r_pkg::QPtrW'(i2r_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == i2r_pkg::QPtrW'(i2r_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: src/i2r_front.sv
module i2r_front (
  i2r_in_if.sink          in_chan_i,
  input  logic            full_i,
  output logic            push_o,
  output i2r_pkg::item_t  item_o
);

  assign in_chan_i.ready = !full_i;
  assign push_o          = in_chan_i.valid && !full_i;

  // Flag zero and anything past the numeral range
  assign item_o.value = in_chan_i.value;
  assign item_o.bad   = (in_chan_i.value == '0) || (in_chan_i.value > i2r_pkg::MaxValue);

endmodule

FILE: src/i2r_back.sv
module i2r_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  i2r_pkg::head_t  head_i,
  output logic            pop_o,
  i2r_out_if.source       out_chan_o
);

  logic                              busy_q, busy_d;
  logic                              pend_q, pend_d;
  logic [i2r_pkg::ValueW-1:0]        rest_q, rest_d;
  logic [i2r_pkg::CharW-1:0]         pend_char_q, pend_char_d;
  logic                              out_valid_q, out_valid_d;
  i2r_pkg::res_t                     res_q, res_d;

  logic                              advance;
  logic [i2r_pkg::ValueW-1:0]        src_rest;
  logic [i2r_pkg::StepW-1:0]         step;
  logic [i2r_pkg::ValueW-1:0]        diff;
  logic [i2r_pkg::CharW-1:0]         second;

  assign advance  = !out_valid_q || out_chan_o.ready;
  assign src_rest = busy_q ? rest_q : head_i.item.value;
  assign step     = i2r_pkg::find_step(src_rest);
  assign diff     = src_rest - i2r_pkg::StepAmount[step];
  assign second   = i2r_pkg::StepSecond[step];

  always_comb begin
    busy_d      = busy_q;
    pend_d      = pend_q;
    rest_d      = rest_q;
    pend_char_d = pend_char_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    pop_o       = 1'b0;
    if (advance) begin
      if (busy_q && pend_q) begin
        // Emit the second half of a subtractive pair
        out_valid_d     = 1'b1;
        res_d.char_code = pend_char_q;
        res_d.last_char = (rest_q == '0);
        res_d.invalid   = 1'b0;
        pend_d          = 1'b0;
        busy_d          = (rest_q != '0);
      end else if (busy_q || head_i.valid) begin
        pop_o       = !busy_q;
        out_valid_d = 1'b1;
        if (!busy_q && head_i.item.bad) begin
          res_d.char_code = i2r_pkg::ChNone;
          res_d.last_char = 1'b1;
          res_d.invalid   = 1'b1;
        end else begin
          res_d.char_code = i2r_pkg::StepFirst[step];
          res_d.invalid   = 1'b0;
          rest_d          = diff;
          if (second != i2r_pkg::ChNone) begin
            pend_d          = 1'b1;
            pend_char_d     = second;
            res_d.last_char = 1'b0;
            busy_d          = 1'b1;
          end else begin
            res_d.last_char = (diff == '0);
            busy_d          = (diff != '0);
          end
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q      <= rest_d;
    pend_char_q <= pend_char_d;
    res_q       <= res_d;
  end

  assign out_chan_o.valid     = out_valid_q;
  assign out_chan_o.char_code = res_q.char_code;
  assign out_chan_o.last_char = res_q.last_char;
  assign out_chan_o.invalid   = res_q.invalid;

endmodule

FILE: src/integer_to_roman_numeral_top.sv
// A value is registered in the queue, then its first character in the back end's output register.
// Throughput: one character per cycle while out_chan_o is not stalled; a numeral has
// 1 to 15 characters, and a zero or out-of-range value gives one invalid character; the greedy
// sequencer in the back end produces one character per cycle.
// A two-entry queue lets the front take values while the back end is still emitting.
// Reset (rst_ni low, asynchronous) empties the queue and drops any result in flight.
module integer_to_roman_numeral_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  i2r_in_if.sink    in_chan_i,
  i2r_out_if.source out_chan_o
);

  logic           push;
  logic           full;
  logic           pop;
  i2r_pkg::item_t item;
  i2r_pkg::head_t head;

  i2r_front u_front (
    .in_chan_i (in_chan_i),
    .full_i    (full),
    .push_o    (push),
    .item_o    (item)
  );

  i2r_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  i2r_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_chan_o (out_chan_o)
  );

endmodule

FILE: src/i2r_checker.sv
`include "integer_to_roman_numeral_top_defines.svh"

module i2r_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] char_code_i,
  input logic       last_char_i,
  input logic       invalid_i
);

  logic legal_char;

  assign legal_char = (char_code_i == i2r_pkg::ChI) || (char_code_i == i2r_pkg::ChV) ||
                      (char_code_i == i2r_pkg::ChX) || (char_code_i == i2r_pkg::ChL) ||
                      (char_code_i == i2r_pkg::ChC) || (char_code_i == i2r_pkg::ChD) ||
                      (char_code_i == i2r_pkg::ChM);

  `I2R_ASSERT_IMP(a_invalid_shape, out_valid_i && invalid_i, (char_code_i == i2r_pkg::ChNone) && last_char_i, "invalid result must be a lone zero character")
  `I2R_ASSERT_IMP(a_legal_char, out_valid_i && !invalid_i, legal_char, "numeral character outside I V X L C D M")
  `I2R_ASSERT_NXT(a_valid_holds, out_valid_i && !out_ready_i, out_valid_i, "result withdrawn while stalled")
  `I2R_ASSERT_NXT(a_payload_holds, out_valid_i && !out_ready_i, $stable(char_code_i) && $stable(last_char_i) && $stable(invalid_i), "result changed while stalled")

endmodule

bind integer_to_roman_numeral_top i2r_checker u_i2r_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_chan_o.valid),
  .out_ready_i (out_chan_o.ready),
  .char_code_i (out_chan_o.char_code),
  .last_char_i (out_chan_o.last_char),
  .invalid_i   (out_chan_o.invalid)
);
